// ----- design/msb_first_bit_field_packer_top_macros.svh -----
// Assertion macros for the bit-field packer; the clock is clk, the reset arst_n.
`ifndef MSB_FIRST_BIT_FIELD_PACKER_TOP_MACROS_SVH
`define MSB_FIRST_BIT_FIELD_PACKER_TOP_MACROS_SVH

// same-cycle implication
`define MBFP_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MBFP_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/mbfp_pkg.sv -----
// Types and constants shared by the bit-field packer modules.
package mbfp_pkg;

	localparam logic       CMD_FIELD = 1'b0;
	localparam logic       CMD_PAD   = 1'b1;
	localparam logic [6:0] FIELD_MAX = 7'd64;
	localparam int         ACC_W     = 72;
	localparam int         BITS_W    = 9;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
	} acc_ctrl_t;

	typedef struct packed {
		logic [7:0] head;
		logic       has_byte;
		logic       final_byte;
		logic [7:0] rest;
	} acc_stat_t;

endpackage

// ----- design/mbfp_acc.sv -----
// Bit accumulator: aligns a field behind the pending bits, then shifts out one byte per step.
module mbfp_acc (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mbfp_pkg::acc_ctrl_t             ctrl,
	input  logic                            cmd,
	input  logic [63:0]                     field_value,
	input  logic [6:0]                      field_bits,
	input  logic [7:0]                      partial,
	input  logic [2:0]                      fill,
	input  logic [mbfp_pkg::BITS_W-1:0]     total_bits,
	output mbfp_pkg::acc_stat_t             stat
);

	logic [mbfp_pkg::ACC_W-1:0]  acc_q;
	logic [mbfp_pkg::BITS_W-1:0] bits_q;
	logic [63:0]                 left_val;
	logic [mbfp_pkg::ACC_W-1:0]  placed;
	logic [mbfp_pkg::ACC_W-1:0]  acc_init;
	logic [6:0]                  lshift;
	logic [3:0]                  pshift;

	// left-align the field (drops stray bits above the width), then place it after the fill
	always_comb begin
		lshift   = 7'(mbfp_pkg::FIELD_MAX - field_bits);
		pshift   = 4'd8 - {1'b0, fill};
		left_val = (cmd == mbfp_pkg::CMD_PAD) ? 64'd0 : (field_value << lshift);
		placed   = {8'd0, left_val} << pshift;
		acc_init = {partial, 64'd0} | placed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
		end else if (ctrl.load) begin
			bits_q <= total_bits;
		end else if (ctrl.step && stat.has_byte) begin
			bits_q <= bits_q - mbfp_pkg::BITS_W'(8);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			acc_q <= acc_init;
		end else if (ctrl.step && stat.has_byte) begin
			acc_q <= {acc_q[mbfp_pkg::ACC_W-9:0], 8'd0};
		end
	end

	always_comb begin
		stat.head       = acc_q[mbfp_pkg::ACC_W-1 -: 8];
		stat.has_byte   = |bits_q[mbfp_pkg::BITS_W-1:3];
		stat.final_byte = ~|bits_q[mbfp_pkg::BITS_W-1:4];
		stat.rest       = stat.has_byte ? acc_q[mbfp_pkg::ACC_W-9 -: 8] : stat.head;
	end

endmodule

// ----- design/msb_first_bit_field_packer_top.sv -----
// Top level of the MSB-first bit-field packer.
// An accepted request is loaded; its results leave through a registered output.
// A request emits a result per completed byte, or an empty result if no byte completes;
// s_tready is low meanwhile; one byte a cycle leaves the shifter while output is free.
// Reset clears pending bits, fill and byte counter; the block is ready right after reset.
`include "msb_first_bit_field_packer_top_macros.svh"

module msb_first_bit_field_packer_top #(
	parameter int COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// [63:0] field_value, [70:64] field_bits, [78:71] pad_total, [86:79] pad_keep, [87] zero
	input  logic [87:0] s_tdata,
	// [0] cmd
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// [7:0] out_byte, [39:8] byte_total
	output logic [39:0] m_tdata,
	// [0] byte_valid, [1] aligned
	output logic [1:0]  m_tuser,
	output logic        m_tlast
);

	localparam int CW = COUNT_BITS + 1;

	mbfp_pkg::state_t            state_q;
	mbfp_pkg::acc_ctrl_t         acc_ctrl;
	mbfp_pkg::acc_stat_t         acc_stat;

	logic                        cmd;
	logic [63:0]                 field_value;
	logic [6:0]                  field_bits;
	logic [7:0]                  pad_total;
	logic [7:0]                  pad_keep;

	logic [6:0]                  nb;
	logic [7:0]                  pad_bits;
	logic [mbfp_pkg::BITS_W-1:0] add_bits;
	logic [mbfp_pkg::BITS_W-1:0] total_bits;
	logic [mbfp_pkg::BITS_W-1:0] round_up;
	logic [5:0]                  started;
	logic [CW-1:0]               count_sum;
	logic [COUNT_BITS-1:0]       count_next;
	logic [31:0]                 byte_total_next;

	logic [7:0]                  partial_q;
	logic [2:0]                  fill_q;
	logic [COUNT_BITS-1:0]       count_q;
	logic                        aligned_q;
	logic [31:0]                 byte_total_q;

	logic                        accept;
	logic                        out_free;
	logic                        emit;
	logic                        emit_last;
	logic [7:0]                  out_byte_q;
	logic                        byte_valid_q;
	logic                        last_q;
	logic                        out_aligned_q;
	logic [31:0]                 out_total_q;

	assign cmd         = s_tuser[0];
	assign field_value = s_tdata[63:0];
	assign field_bits  = s_tdata[70:64];
	assign pad_total   = s_tdata[78:71];
	assign pad_keep    = s_tdata[86:79];

	assign s_tready  = (state_q == mbfp_pkg::ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign out_free  = !m_tvalid || m_tready;
	assign emit      = (state_q == mbfp_pkg::ST_RUN) && out_free;
	assign emit_last = !acc_stat.has_byte || acc_stat.final_byte;

	// bits this request appends, and bytes newly started by them
	always_comb begin
		nb         = (field_bits > mbfp_pkg::FIELD_MAX) ? mbfp_pkg::FIELD_MAX : field_bits;
		pad_bits   = (pad_total > pad_keep) ? (pad_total - pad_keep) : 8'd0;
		add_bits   = (cmd == mbfp_pkg::CMD_PAD) ? {1'b0, pad_bits} : {2'b00, nb};
		total_bits = add_bits + {6'd0, fill_q};
		round_up   = total_bits + mbfp_pkg::BITS_W'(7);
		started    = round_up[mbfp_pkg::BITS_W-1:3] - {5'd0, (fill_q != 3'd0)};
		count_sum  = {1'b0, count_q} + CW'(started);
		count_next = count_sum[CW-1] ? {COUNT_BITS{1'b1}} : count_sum[COUNT_BITS-1:0];
	end

	generate
		if (COUNT_BITS > 32) begin : g_total_sat
			assign byte_total_next = (|count_next[COUNT_BITS-1:32]) ? 32'hffff_ffff
			                                                        : count_next[31:0];
		end else begin : g_total_ext
			assign byte_total_next = 32'(count_next);
		end
	endgenerate

	always_comb begin
		acc_ctrl.load = accept;
		acc_ctrl.step = emit;
	end

	mbfp_acc u_acc (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (acc_ctrl),
		.cmd         (cmd),
		.field_value (field_value),
		.field_bits  (nb),
		.partial     (partial_q),
		.fill        (fill_q),
		.total_bits  (total_bits),
		.stat        (acc_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= mbfp_pkg::ST_IDLE;
			partial_q    <= '0;
			fill_q       <= '0;
			count_q      <= '0;
			aligned_q    <= 1'b1;
			byte_total_q <= '0;
			m_tvalid     <= 1'b0;
		end else begin
			case (state_q)
				mbfp_pkg::ST_IDLE: begin
					if (accept) begin
						state_q      <= mbfp_pkg::ST_RUN;
						fill_q       <= total_bits[2:0];
						count_q      <= count_next;
						aligned_q    <= (total_bits[2:0] == 3'd0);
						byte_total_q <= byte_total_next;
					end
				end
				mbfp_pkg::ST_RUN: begin
					if (emit && emit_last) begin
						partial_q <= acc_stat.rest;
						state_q   <= mbfp_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= mbfp_pkg::ST_IDLE;
				end
			endcase

			if (emit) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q    <= acc_stat.has_byte ? acc_stat.head : 8'd0;
			byte_valid_q  <= acc_stat.has_byte;
			last_q        <= emit_last;
			out_aligned_q <= aligned_q;
			out_total_q   <= byte_total_q;
		end
	end

	assign m_tdata = {out_total_q, out_byte_q};
	assign m_tuser = {out_aligned_q, byte_valid_q};
	assign m_tlast = last_q;

	`MBFP_ASSERT_NXT(a_busy_after_accept, accept, !s_tready, "ready high right after a request")
	`MBFP_ASSERT_IMP(a_empty_is_last, m_tvalid && !m_tuser[0], m_tlast, "empty result not last")
	`MBFP_ASSERT_NXT(a_run_fills_output, (state_q == mbfp_pkg::ST_RUN) && !m_tvalid, m_tvalid,
		"output slot left empty while busy")

endmodule

// ----- tb/packed_byte_checker.sv -----
// Checker for the bit-field packer: watches both streams, predicts the packed bytes, compares.
module packed_byte_checker #(
	parameter int COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [87:0] s_tdata,
	input  logic [0:0]  s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic [1:0]  m_tuser,
	input  logic        m_tlast,
	output int          fail_count,
	output int          pending,
	output int          results_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic        last;
		logic        aligned;
		logic [31:0] total;
	} packed_result_t;

	// model of the packing state
	logic [7:0]        pend_byte;
	int unsigned       pend_bits;
	longint unsigned   started_bytes;
	logic [7:0]        done_bytes[$];
	packed_result_t    expected_bytes_q[$];

	initial begin
		fail_count = 0;
		pending = 0;
		results_seen = 0;
		pend_byte = '0;
		pend_bits = 0;
		started_bytes = 0;
	end

	function automatic void shift_in(logic b);
		longint unsigned cap;
		cap = (64'd1 << COUNT_BITS) - 64'd1;
		if (pend_bits == 0 && started_bytes < cap)
			started_bytes++;
		if (b)
			pend_byte[7 - pend_bits] = 1'b1;
		pend_bits++;
		if (pend_bits == 8) begin
			done_bytes.push_back(pend_byte);
			pend_byte = '0;
			pend_bits = 0;
		end
	endfunction

	function automatic void predict_packing(logic cmd, logic [63:0] val, logic [6:0] nbits,
	                                        logic [7:0] ptotal, logic [7:0] pkeep);
		int n;
		logic [31:0] tot;
		packed_result_t r;
		done_bytes.delete();
		if (cmd == mbfp_pkg::CMD_FIELD) begin
			n = (nbits > mbfp_pkg::FIELD_MAX) ? int'(mbfp_pkg::FIELD_MAX) : int'(nbits);
			for (int i = n - 1; i >= 0; i--)
				shift_in(val[i]);
		end else if (ptotal > pkeep) begin
			for (int i = 0; i < int'(ptotal) - int'(pkeep); i++)
				shift_in(1'b0);
		end
		tot = (started_bytes > 64'hffff_ffff) ? 32'hffff_ffff : started_bytes[31:0];
		if (done_bytes.size() == 0) begin
			r = '{out_byte: 8'h00, byte_valid: 1'b0, last: 1'b1, aligned: (pend_bits == 0),
			      total: tot};
			expected_bytes_q.push_back(r);
		end else begin
			foreach (done_bytes[k]) begin
				r = '{out_byte: done_bytes[k], byte_valid: 1'b1,
				      last: (k == done_bytes.size() - 1), aligned: (pend_bits == 0), total: tot};
				expected_bytes_q.push_back(r);
			end
		end
	endfunction

	always @(posedge clk) begin
		packed_result_t e;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				predict_packing(s_tuser[0], s_tdata[63:0], s_tdata[70:64], s_tdata[78:71],
				                s_tdata[86:79]);
			if (m_tvalid && m_tready) begin
				results_seen++;
				if (expected_bytes_q.size() == 0) begin
					$error("unexpected result: out_byte %0h total %0d", m_tdata[7:0],
					       m_tdata[39:8]);
					fail_count++;
				end else begin
					e = expected_bytes_q.pop_front();
					if (m_tdata[7:0] !== e.out_byte) begin
						$error("out_byte: expected %0h, got %0h", e.out_byte, m_tdata[7:0]);
						fail_count++;
					end
					if (m_tuser[0] !== e.byte_valid) begin
						$error("byte_valid: expected %0b, got %0b", e.byte_valid, m_tuser[0]);
						fail_count++;
					end
					if (m_tlast !== e.last) begin
						$error("last_result: expected %0b, got %0b", e.last, m_tlast);
						fail_count++;
					end
					if (m_tuser[1] !== e.aligned) begin
						$error("aligned: expected %0b, got %0b", e.aligned, m_tuser[1]);
						fail_count++;
					end
					if (m_tdata[39:8] !== e.total) begin
						$error("byte_total: expected %0d, got %0d", e.total, m_tdata[39:8]);
						fail_count++;
					end
				end
			end
			pending = expected_bytes_q.size();
		end
	end

endmodule

// ----- tb/msb_first_bit_field_packer_top_tb.sv -----
// Testbench top for the bit-field packer: clock, reset, request and result traffic, verdict.
module msb_first_bit_field_packer_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_REQS = 380;
	localparam int CYCLE_LIMIT = 800000;
	localparam int HOLD_CYCLES = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [87:0] s_tdata = '0;
	logic [0:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	int fail_count;
	int pending;
	int results_seen;
	int field_reqs = 0;
	int pad_reqs = 0;
	int taken = 0;
	int cycle_count = 0;

	always #2 clk = ~clk;

	msb_first_bit_field_packer_top #(.COUNT_BITS(32)) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	packed_byte_checker #(.COUNT_BITS(32)) i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.m_tlast      (m_tlast),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// called at a rising edge; returns at the edge where the request is taken
	task automatic send_request(logic cmd, logic [63:0] val, logic [6:0] nbits,
	                            logic [7:0] ptotal, logic [7:0] pkeep, bit quiet);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {1'b0, pkeep, ptotal, nbits, val};
		if (cmd == mbfp_pkg::CMD_FIELD)
			field_reqs++;
		else
			pad_reqs++;
		do @(negedge clk); while (!s_tready);
		@(posedge clk);
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// result side: random stalls, quiet stretches and one long hold-off
	initial begin
		int stall;
		bit held;
		held = 0;
		@(posedge clk iff arst_n);
		forever begin
			if (!held && taken == 150) begin
				held = 1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = (((taken / 50) % 5) == 2) ? 0 : $urandom_range(0, 13);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(negedge clk); while (!m_tvalid);
			@(posedge clk);
			taken++;
		end
	end

	initial begin
		logic        cmd;
		logic [63:0] val;
		logic [6:0]  nbits;
		logic [7:0]  ptotal;
		logic [7:0]  pkeep;
		int          sel;
		int          diff;
		bit          quiet;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field widths at the edges, stray bits, padding corner cases
		send_request(mbfp_pkg::CMD_FIELD, 64'hffff_ffff_ffff_ffff, 7'd0, 8'd0, 8'd0, 1'b0);
		send_request(mbfp_pkg::CMD_FIELD, 64'h1, 7'd1, 8'd0, 8'd0, 1'b0);
		send_request(mbfp_pkg::CMD_FIELD, 64'hffff_ffff_ffff_fffe, 7'd1, 8'd0, 8'd0, 1'b0);
		send_request(mbfp_pkg::CMD_PAD, 64'hffff_ffff_ffff_ffff, 7'd127, 8'd6, 8'd0, 1'b0);
		send_request(mbfp_pkg::CMD_FIELD, 64'hffff_ffff_ffff_ffff, 7'd64, 8'd255, 8'd255, 1'b0);
		send_request(mbfp_pkg::CMD_FIELD, 64'h0, 7'd64, 8'd0, 8'd0, 1'b0);
		send_request(mbfp_pkg::CMD_FIELD, 64'h8000_0000_0000_0001, 7'd127, 8'd0, 8'd0, 1'b0);
		send_request(mbfp_pkg::CMD_FIELD, 64'h0123_4567_89ab_cdef, 7'd65, 8'd0, 8'd0, 1'b0);
		send_request(mbfp_pkg::CMD_FIELD, 64'hffff_ffff_ffff_fff5, 7'd3, 8'd0, 8'd0, 1'b0);
		send_request(mbfp_pkg::CMD_PAD, 64'h0, 7'd0, 8'd255, 8'd0, 1'b0);
		send_request(mbfp_pkg::CMD_FIELD, 64'h5a, 7'd7, 8'd0, 8'd0, 1'b0);
		send_request(mbfp_pkg::CMD_PAD, 64'h0, 7'd0, 8'd255, 8'd0, 1'b0);
		send_request(mbfp_pkg::CMD_PAD, 64'h0, 7'd0, 8'd0, 8'd255, 1'b0);
		send_request(mbfp_pkg::CMD_PAD, 64'h0, 7'd0, 8'd100, 8'd100, 1'b0);
		send_request(mbfp_pkg::CMD_PAD, 64'h0, 7'd0, 8'd1, 8'd0, 1'b0);
		send_request(mbfp_pkg::CMD_PAD, 64'h0, 7'd0, 8'd8, 8'd0, 1'b0);
		send_request(mbfp_pkg::CMD_FIELD, 64'h3, 7'd2, 8'd0, 8'd0, 1'b0);
		send_request(mbfp_pkg::CMD_PAD, 64'h0, 7'd0, 8'd16, 8'd10, 1'b0);
		send_request(mbfp_pkg::CMD_FIELD, 64'hdead_beef, 7'd32, 8'd0, 8'd0, 1'b0);
		send_request(mbfp_pkg::CMD_FIELD, 64'h7fff_ffff_ffff_ffff, 7'd63, 8'd0, 8'd0, 1'b0);
		send_request(mbfp_pkg::CMD_FIELD, 64'haaaa_aaaa_aaaa_aaaa, 7'd64, 8'd0, 8'd0, 1'b0);

		// sender pauses until every pending result is back
		drain();

		for (int n = 0; n < RANDOM_REQS; n++) begin
			quiet = ((n / 40) % 4) == 3;
			val = {$urandom, $urandom};
			ptotal = 8'($urandom_range(0, 255));
			pkeep = 8'($urandom_range(0, 255));
			nbits = 7'($urandom_range(0, 127));
			cmd = ($urandom_range(0, 9) < 7) ? mbfp_pkg::CMD_FIELD : mbfp_pkg::CMD_PAD;
			sel = $urandom_range(0, 99);
			if (cmd == mbfp_pkg::CMD_FIELD) begin
				if (sel < 8)
					nbits = 7'd0;
				else if (sel < 18)
					nbits = 7'($urandom_range(65, 127));
				else if (sel < 30)
					nbits = mbfp_pkg::FIELD_MAX;
				else
					nbits = 7'($urandom_range(1, 63));
			end else begin
				if (sel < 15) begin
					pkeep = 8'($urandom_range(ptotal, 255));
				end else if (sel >= 25) begin
					diff = $urandom_range(1, 24);
					pkeep = (ptotal > diff) ? 8'(int'(ptotal) - diff) : 8'd0;
				end
			end
			send_request(cmd, val, nbits, ptotal, pkeep, quiet);
		end

		drain();
		repeat (20) @(posedge clk);

		$display("Sent %0d field and %0d padding requests; %0d result beats checked.",
		         field_reqs, pad_reqs, results_seen);
		$display("Covered zero, odd and oversized field widths, stray value bits, padding extremes.");
		if (fail_count == 0 && pending == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
